### rtl/crpc_pkg.sv
// Shared constants and types for the clip region point cache.
// No dependencies.
`default_nettype none
package crpc_pkg;
    localparam int MAX_RECTS = 16;
    localparam int IDX_W = $clog2(MAX_RECTS);
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_COMMIT = 2'd1;
    localparam logic [1:0] ACT_POINT = 2'd2;
    localparam logic [1:0] ACT_AREA = 2'd3;
    localparam logic [1:0] CFG_WIDTH = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;
    localparam logic [1:0] CLS_INVIS = 2'd0;
    localparam logic [1:0] CLS_VIS = 2'd1;
    localparam logic [1:0] CLS_PART = 2'd2;
    localparam logic signed [16:0] COORD_LO = -17'sd32768;
    localparam logic signed [16:0] COORD_HI = 17'sd32767;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         rect_index;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic signed [15:0] x_first;
        logic signed [15:0] y_first;
        logic signed [15:0] x_second;
        logic signed [15:0] y_second;
    } t_in;

    typedef struct packed {
        logic       point_visible;
        logic [1:0] area_class;
    } t_out;

    typedef struct packed {
        logic [1:0] index;
        logic [14:0] data;
    } t_cfg;
endpackage
`default_nettype wire

### rtl/crpc_if.sv
// Valid/ready channel interfaces for items, results and configuration.
// Depends on crpc_pkg.
`default_nettype none
interface crpc_in_if;
    logic valid;
    logic ready;
    crpc_pkg::t_in data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface crpc_out_if;
    logic valid;
    logic ready;
    crpc_pkg::t_out data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface crpc_cfg_if;
    logic valid;
    logic ready;
    crpc_pkg::t_cfg data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/crpc_front.sv
// Front part: accepts words and queues them (two entries) toward the back part.
// Depends on crpc_pkg.
`default_nettype none
module crpc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire crpc_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output crpc_pkg::t_in       o_data
);
    crpc_pkg::t_in r_q [2];
    logic [1:0] r_cnt;
    logic r_rd;
    logic r_wr;
    logic push;
    logic pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_q[r_rd];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### rtl/crpc_back.sv
// Back part: rectangle table, cache and the sequencer that runs each word.
// Depends on crpc_pkg.
`default_nettype none
module crpc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire crpc_pkg::t_in  i_data,
    input  wire logic [14:0]    i_width,
    input  wire logic [14:0]    i_height,
    input  wire logic [4:0]     i_count,
    output logic                o_valid,
    input  wire logic           i_ready,
    output crpc_pkg::t_out      o_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_HIT = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [63:0] r_mem [crpc_pkg::MAX_RECTS];
    logic [63:0] r_rdata;
    logic [2:0] r_state;
    crpc_pkg::t_in r_item;
    logic [crpc_pkg::CNT_W-1:0] r_i;
    logic [crpc_pkg::CNT_W-1:0] live;
    logic [crpc_pkg::IDX_W-1:0] rd_addr;
    logic signed [16:0] r_x0, r_x1, r_y0, r_y1;
    logic r_vis;
    logic r_pv;
    logic r_ovalid;
    crpc_pkg::t_out r_out;
    logic signed [16:0] px, py, bx, by, tl, tt, tr, tb, w, h;
    logic in_a, in_b;
    logic go_scan;
    logic [1:0] cls;

    assign live = (i_count > 5'(crpc_pkg::MAX_RECTS)) ? crpc_pkg::CNT_W'(crpc_pkg::MAX_RECTS)
                                                      : crpc_pkg::CNT_W'(i_count);
    assign px = 17'(r_item.x_first);
    assign py = 17'(r_item.y_first);
    assign bx = 17'(r_item.x_second);
    assign by = 17'(r_item.y_second);
    assign tl = 17'($signed(r_rdata[63:48]));
    assign tt = 17'($signed(r_rdata[47:32]));
    assign tr = 17'($signed(r_rdata[31:16]));
    assign tb = 17'($signed(r_rdata[15:0]));
    assign w = $signed({2'b00, i_width});
    assign h = $signed({2'b00, i_height});
    assign in_a = px >= r_x0 && px <= r_x1 && py >= r_y0 && py <= r_y1;
    assign in_b = bx >= r_x0 && bx <= r_x1 && by >= r_y0 && by <= r_y1;
    assign go_scan = (r_item.action == crpc_pkg::ACT_POINT || r_item.action == crpc_pkg::ACT_AREA)
                     && !in_a && px >= 0 && py >= 0 && px < w && py < h && live != '0;
    assign cls = in_b ? (r_vis ? crpc_pkg::CLS_VIS : crpc_pkg::CLS_INVIS) : crpc_pkg::CLS_PART;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_comb begin
        rd_addr = r_i[crpc_pkg::IDX_W-1:0];
        if (r_state == S_IDLE || r_state == S_DONE) rd_addr = '0;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (r_state == S_IDLE && i_valid && i_data.action == crpc_pkg::ACT_LOAD) begin
            r_mem[i_data.rect_index[crpc_pkg::IDX_W-1:0]] <= {i_data.rect_left,
                i_data.rect_top, i_data.rect_right, i_data.rect_bottom};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) r_item <= i_data;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_x0 <= crpc_pkg::COORD_LO;
            r_x1 <= crpc_pkg::COORD_HI;
            r_y0 <= crpc_pkg::COORD_LO;
            r_y1 <= crpc_pkg::COORD_HI;
            r_vis <= 1'b0;
            r_pv <= 1'b0;
            r_i <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    if (i_valid) begin
                        r_state <= S_DISP;
                        r_pv <= 1'b0;
                    end
                end
                S_DISP: begin
                    r_state <= go_scan ? S_HIT : S_DONE;
                    if (r_item.action == crpc_pkg::ACT_COMMIT) begin
                        if (live == '0) begin
                            r_x0 <= crpc_pkg::COORD_LO; r_x1 <= crpc_pkg::COORD_HI;
                            r_y0 <= crpc_pkg::COORD_LO; r_y1 <= crpc_pkg::COORD_HI;
                            r_vis <= 1'b0;
                        end else begin
                            r_x0 <= tl; r_x1 <= tr - 17'sd1;
                            r_y0 <= tt; r_y1 <= tb - 17'sd1;
                            r_vis <= 1'b1;
                        end
                    end else if (r_item.action == crpc_pkg::ACT_POINT
                                 || r_item.action == crpc_pkg::ACT_AREA) begin
                        if (in_a) begin
                            r_pv <= (r_item.action == crpc_pkg::ACT_POINT) && r_vis;
                        end else if (px < 0) begin
                            r_x0 <= crpc_pkg::COORD_LO; r_x1 <= -17'sd1;
                            r_y0 <= crpc_pkg::COORD_LO; r_y1 <= crpc_pkg::COORD_HI;
                            r_vis <= 1'b0;
                        end else if (py < 0) begin
                            r_x0 <= crpc_pkg::COORD_LO; r_x1 <= crpc_pkg::COORD_HI;
                            r_y0 <= crpc_pkg::COORD_LO; r_y1 <= -17'sd1;
                            r_vis <= 1'b0;
                        end else if (px >= w) begin
                            r_x0 <= w; r_x1 <= crpc_pkg::COORD_HI;
                            r_y0 <= crpc_pkg::COORD_LO; r_y1 <= crpc_pkg::COORD_HI;
                            r_vis <= 1'b0;
                        end else if (py >= h) begin
                            r_x0 <= crpc_pkg::COORD_LO; r_x1 <= crpc_pkg::COORD_HI;
                            r_y0 <= h; r_y1 <= crpc_pkg::COORD_HI;
                            r_vis <= 1'b0;
                        end else if (live == '0) begin
                            r_x0 <= 17'sd0; r_x1 <= w - 17'sd1;
                            r_y0 <= 17'sd0; r_y1 <= h - 17'sd1;
                            r_vis <= 1'b1;
                            r_pv <= (r_item.action == crpc_pkg::ACT_POINT);
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_HIT: begin
                    if (px >= tl && py >= tt && px < tr && py < tb) begin
                        r_x0 <= tl; r_x1 <= tr - 17'sd1;
                        r_y0 <= tt; r_y1 <= tb - 17'sd1;
                        r_vis <= 1'b1;
                        r_pv <= (r_item.action == crpc_pkg::ACT_POINT);
                        r_state <= S_DONE;
                    end else if (r_i == live) begin
                        r_x0 <= crpc_pkg::COORD_LO; r_x1 <= crpc_pkg::COORD_HI;
                        r_y0 <= crpc_pkg::COORD_LO; r_y1 <= crpc_pkg::COORD_HI;
                        r_vis <= 1'b0;
                        r_i <= '0;
                        r_state <= S_MISS;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_MISS: begin
                    // While r_i is zero this state only waits for entry zero to be read.
                    if (r_i != '0) begin
                        if (px < tl && tl <= r_x1) r_x1 <= tl - 17'sd1;
                        if (px > tr - 17'sd1 && tr - 17'sd1 >= r_x0) r_x0 <= tr;
                        if (py < tt && tt <= r_y1) r_y1 <= tt - 17'sd1;
                        if (py > tb - 17'sd1 && tb - 17'sd1 >= r_y0) r_y0 <= tb;
                    end
                    if (r_i == live) r_state <= S_DONE;
                    else r_i <= r_i + 1'b1;
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_out <= {r_pv, (r_item.action == crpc_pkg::ACT_AREA) ? cls
                                                                 : crpc_pkg::CLS_INVIS};
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/clip_region_point_cache_core.sv
// Top level of the clip region point cache: configuration registers,
// front queue and back sequencer. Depends on crpc_pkg, crpc_if, crpc_front, crpc_back.
// A cache miss inside the screen scans a table of up to sixteen rectangles.
// The back sequencer takes one word at a time; the front queue holds two.
// Reset (synchronous, active low) restores 640 x 480, count 0 and a whole-plane cache.
`default_nettype none
module clip_region_point_cache_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crpc_in_if.sink   in_ch,
    crpc_out_if.source out_ch,
    crpc_cfg_if.sink  cfg_ch
);
    logic [14:0] r_width;
    logic [14:0] r_height;
    logic [4:0]  r_count;
    logic q_valid;
    logic q_ready;
    crpc_pkg::t_in q_data;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 15'd640;
            r_height <= 15'd480;
            r_count <= 5'd0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.data.index)
                crpc_pkg::CFG_WIDTH: r_width <= cfg_ch.data.data;
                crpc_pkg::CFG_HEIGHT: r_height <= cfg_ch.data.data;
                crpc_pkg::CFG_COUNT: r_count <= cfg_ch.data.data[4:0];
                default: ;
            endcase
        end
    end

    crpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_data(in_ch.data),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    crpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_data(q_data),
        .i_width(r_width), .i_height(r_height), .i_count(r_count),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_data(out_ch.data)
    );
endmodule
`default_nettype wire
